// ===== design/wavhdr_pkg.sv =====
// Shared types and codes for the WAV header chunk parser.
`default_nettype none

package wavhdr_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_AUDIO  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOT_RIFF = 3'd1,
    ERR_NOT_WAVE = 3'd2,
    ERR_FMT_SHORT = 3'd3,
    ERR_FORMAT   = 3'd4,
    ERR_WIDTH    = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } in_slot_t;

  typedef struct packed {
    kind_e       kind;
    err_e        error_code;
    logic [15:0] wave_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [4:0]  sample_width;
    logic [31:0] data_length;
    logic [31:0] audio_start;
    logic [7:0]  audio_byte;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/wavhdr_in_reg.sv =====
// Input register: holds one accepted byte request until the parser takes it.
`default_nettype none

module wavhdr_in_reg
  import wavhdr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire item_t    in_item_i,
  output logic          in_ready_o,
  input  wire logic     advance_i,
  output in_slot_t      slot_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      item_d  = in_item_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.item  = item_q;

endmodule

`default_nettype wire

// ===== design/wavhdr_parser.sv =====
// Parser state machine: consumes one byte per advance and forms its result.
`default_nettype none

module wavhdr_parser
  import wavhdr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     pcm_only_i,
  input  wire in_slot_t slot_i,
  input  wire logic     advance_i,
  output logic          res_valid_o,
  output result_t       res_o
);

  typedef enum logic [3:0] {
    PH_RIFF   = 4'd0,
    PH_RLEN   = 4'd1,
    PH_WAVE   = 4'd2,
    PH_CTAG   = 4'd3,
    PH_CLEN   = 4'd4,
    PH_SKIP   = 4'd5,
    PH_FTAG   = 4'd6,
    PH_FCH    = 4'd7,
    PH_FRATE  = 4'd8,
    PH_FAVG   = 4'd9,
    PH_FALIGN = 4'd10,
    PH_FBITS  = 4'd11,
    PH_DATA   = 4'd12,
    PH_IDLE   = 4'd13
  } phase_e;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666d_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  function automatic logic refused(input logic [15:0] t, input logic pcm_only);
    logic r;
    if (pcm_only) begin
      r = (t != 16'h0001);
    end else begin
      r = (t == 16'h0000) || (t == 16'h0002) || (t == 16'h0006) ||
          (t == 16'h0007) || (t == 16'h0010) || (t == 16'h0015) ||
          (t == 16'h0016) || (t == 16'h0101) || (t == 16'h0102) ||
          (t == 16'h0103);
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] lasm_q, lasm_d;
  logic [32:0] skip_q, skip_d;
  logic [31:0] pos_q, pos_d;
  logic [15:0] ftag_q, ftag_d;
  logic [15:0] fch_q, fch_d;
  logic [31:0] frate_q, frate_d;
  logic [4:0]  fwid_q, fwid_d;
  logic [31:0] drem_q, drem_d;

  // A first byte restarts the file before the byte itself is parsed.
  logic        restart;
  phase_e      eff_phase;
  logic [1:0]  eff_cnt;
  logic [31:0] eff_tag, eff_lasm, eff_pos, eff_drem;
  logic [32:0] eff_skip;
  logic [4:0]  eff_fwid;

  assign restart   = slot_i.item.first_byte;
  assign eff_phase = restart ? PH_RIFF : phase_q;
  assign eff_cnt   = restart ? 2'd0 : cnt_q;
  assign eff_tag   = restart ? '0 : tag_q;
  assign eff_lasm  = restart ? '0 : lasm_q;
  assign eff_skip  = restart ? '0 : skip_q;
  assign eff_pos   = restart ? '0 : pos_q;
  assign eff_fwid  = restart ? '0 : fwid_q;
  assign eff_drem  = restart ? '0 : drem_q;

  logic [7:0]  b;
  logic [31:0] tag_word, le_word;
  logic [32:0] padded;
  logic        done2, done4;

  assign b        = slot_i.item.data_byte;
  assign tag_word = {eff_tag[23:0], b};
  assign le_word  = eff_lasm | ({24'd0, b} << {eff_cnt, 3'b000});
  assign padded   = {1'b0, le_word} + {32'd0, le_word[0]};
  assign done2    = (eff_cnt == 2'd1);
  assign done4    = (eff_cnt == 2'd3);

  kind_e       kind;
  err_e        err;
  logic        res_valid;
  logic [31:0] res_len, res_off;
  logic [7:0]  res_byte;
  logic        res_last;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    tag_d     = tag_q;
    lasm_d    = lasm_q;
    skip_d    = skip_q;
    pos_d     = pos_q;
    ftag_d    = ftag_q;
    fch_d     = fch_q;
    frate_d   = frate_q;
    fwid_d    = fwid_q;
    drem_d    = drem_q;
    kind      = KIND_HEADER;
    err       = ERR_NONE;
    res_valid = 1'b0;
    res_len   = '0;
    res_off   = '0;
    res_byte  = '0;
    res_last  = 1'b0;
    if (advance_i) begin
      phase_d = eff_phase;
      cnt_d   = eff_cnt;
      tag_d   = eff_tag;
      lasm_d  = eff_lasm;
      skip_d  = eff_skip;
      pos_d   = eff_pos;
      ftag_d  = restart ? '0 : ftag_q;
      fch_d   = restart ? '0 : fch_q;
      frate_d = restart ? '0 : frate_q;
      fwid_d  = eff_fwid;
      drem_d  = eff_drem;
      if (eff_phase >= PH_IDLE) begin
        phase_d = PH_IDLE;
      end else begin
        pos_d = eff_pos + 32'd1;
        case (eff_phase)
          PH_RIFF, PH_WAVE, PH_CTAG: begin
            tag_d = tag_word;
            cnt_d = done4 ? 2'd0 : eff_cnt + 2'd1;
            if (done4) begin
              if (eff_phase == PH_RIFF) begin
                if (tag_word != TagRiff) err = ERR_NOT_RIFF;
                else phase_d = PH_RLEN;
              end else if (eff_phase == PH_WAVE) begin
                if (tag_word != TagWave) err = ERR_NOT_WAVE;
                else phase_d = PH_CTAG;
              end else begin
                phase_d = PH_CLEN;
              end
            end
          end
          PH_RLEN, PH_FRATE, PH_FAVG, PH_CLEN: begin
            lasm_d = done4 ? '0 : le_word;
            cnt_d  = done4 ? 2'd0 : eff_cnt + 2'd1;
            if (done4) begin
              case (eff_phase)
                PH_RLEN:  phase_d = PH_WAVE;
                PH_FRATE: begin
                  frate_d = le_word;
                  phase_d = PH_FAVG;
                end
                PH_FAVG:  phase_d = PH_FALIGN;
                default: begin
                  if (eff_fwid == '0 && eff_tag == TagFmt) begin
                    if (le_word < 32'd16) begin
                      err = ERR_FMT_SHORT;
                    end else begin
                      skip_d  = padded - 33'd16;
                      phase_d = PH_FTAG;
                    end
                  end else if (eff_fwid != '0 && eff_tag == TagData) begin
                    drem_d    = le_word;
                    res_valid = 1'b1;
                    kind      = KIND_HEADER;
                    res_len   = le_word;
                    res_off   = eff_pos + 32'd1;
                    phase_d   = (le_word != '0) ? PH_DATA : PH_IDLE;
                  end else begin
                    skip_d  = padded;
                    phase_d = (padded != '0) ? PH_SKIP : PH_CTAG;
                  end
                end
              endcase
            end
          end
          PH_FTAG, PH_FCH, PH_FALIGN, PH_FBITS: begin
            lasm_d = done2 ? '0 : le_word;
            cnt_d  = done2 ? 2'd0 : eff_cnt + 2'd1;
            if (done2) begin
              case (eff_phase)
                PH_FTAG: begin
                  ftag_d = le_word[15:0];
                  if (refused(le_word[15:0], pcm_only_i)) err = ERR_FORMAT;
                  else phase_d = PH_FCH;
                end
                PH_FCH: begin
                  fch_d   = le_word[15:0];
                  phase_d = PH_FRATE;
                end
                PH_FALIGN: phase_d = PH_FBITS;
                default: begin
                  if (le_word != 32'd8 && le_word != 32'd16) begin
                    err = ERR_WIDTH;
                  end else begin
                    fwid_d  = le_word[4:0];
                    phase_d = (eff_skip != '0) ? PH_SKIP : PH_CTAG;
                  end
                end
              endcase
            end
          end
          PH_SKIP: begin
            skip_d = eff_skip - 33'd1;
            if (skip_d == '0) phase_d = PH_CTAG;
          end
          PH_DATA: begin
            res_valid = 1'b1;
            kind      = KIND_AUDIO;
            res_byte  = b;
            res_last  = (eff_drem == 32'd1);
            drem_d    = eff_drem - 32'd1;
            if (drem_d == '0) phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
        // Running out of file before the parse completes replaces the result.
        if (err == ERR_NONE && slot_i.item.end_of_file && phase_d != PH_IDLE) begin
          err = ERR_TRUNC;
        end
        if (err != ERR_NONE) begin
          phase_d   = PH_IDLE;
          res_valid = 1'b1;
          kind      = KIND_REJECT;
        end
      end
    end
  end

  always_comb begin
    res_o = '0;
    res_o.kind       = kind;
    res_o.error_code = err;
    if (kind != KIND_REJECT) begin
      res_o.wave_format   = ftag_d;
      res_o.channel_count = fch_d;
      res_o.sample_rate   = frate_d;
      res_o.sample_width  = fwid_d;
      res_o.data_length   = res_len;
      res_o.audio_start   = res_off;
      res_o.audio_byte    = res_byte;
      res_o.last          = res_last;
    end
  end

  assign res_valid_o = res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      cnt_q   <= '0;
      tag_q   <= '0;
      lasm_q  <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      ftag_q  <= '0;
      fch_q   <= '0;
      frate_q <= '0;
      fwid_q  <= '0;
      drem_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      lasm_q  <= lasm_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      ftag_q  <= ftag_d;
      fch_q   <= fch_d;
      frate_q <= frate_d;
      fwid_q  <= fwid_d;
      drem_q  <= drem_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/wavhdr_out_reg.sv =====
// Result register: holds one result until the downstream side takes it.
`default_nettype none

module wavhdr_out_reg
  import wavhdr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output result_t      res_o,
  output logic         free_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/wav_header_chunk_parser.sv =====
// Top level of the WAV header chunk parser.
// Feed a RIFF/WAVE file one byte per request; tuser marks the first byte of a
// file and tlast the final byte the source has. The block checks the RIFF and
// WAVE tags, walks chunks, reads fmt, then emits one header result at the data
// chunk, one result per audio byte (tlast on the final one), or one rejection
// carrying an error code. It takes one byte every cycle while the result register
// is free; each byte crosses an input register, one parser step and a result
// register. The parser's state update per byte is the only loop and sets that
// byte rate. Write cfg_wdata_i (1 = accept only PCM) only while no request is
// in flight.
`default_nettype none

module wav_header_chunk_parser
  import wavhdr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] first_byte
  input  wire logic         s_axis_tlast,   // end_of_file
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata,   // error_code, wave_format, channel_count,
                                            // sample_rate, sample_width, data_length,
                                            // audio_start, audio_byte (low bit up)
  output logic [1:0]        m_axis_tuser,   // [1:0] kind
  output logic              m_axis_tlast    // last
);

  logic     pcm_only_q;
  item_t    in_item;
  in_slot_t slot;
  logic     advance;
  logic     out_free;
  logic     res_valid;
  result_t  res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcm_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      pcm_only_q <= cfg_wdata_i;
    end
  end

  assign in_item.data_byte   = s_axis_tdata;
  assign in_item.first_byte  = s_axis_tuser;
  assign in_item.end_of_file = s_axis_tlast;

  // Advance the held byte whenever the result register can take its result.
  assign advance = slot.valid && out_free;

  wavhdr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_item_i  (in_item),
    .in_ready_o (s_axis_tready),
    .advance_i  (advance),
    .slot_o     (slot)
  );

  wavhdr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pcm_only_i  (pcm_only_q),
    .slot_i      (slot),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wavhdr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .res_o       (out_res),
    .free_o      (out_free)
  );

  assign m_axis_tdata = {out_res.audio_byte, out_res.audio_start, out_res.data_length,
                         out_res.sample_width, out_res.sample_rate, out_res.channel_count,
                         out_res.wave_format, out_res.error_code};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.kind == KIND_REJECT |->
      out_res.wave_format == '0 && out_res.data_length == '0 && !out_res.last)
    else $error("rejection carries header fields");

  a_good_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.kind != KIND_REJECT |-> out_res.error_code == ERR_NONE)
    else $error("accepted result carries an error code");

  a_last_audio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> out_res.kind == KIND_AUDIO)
    else $error("last flag outside audio");

  a_header_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.kind == KIND_HEADER |->
      (out_res.sample_width == 5'd8 || out_res.sample_width == 5'd16) &&
      out_res.audio_byte == '0)
    else $error("header without a valid sample width");

endmodule

`default_nettype wire

// ===== test/wav_header_chunk_parser_test.sv =====
// Self-checking testbench for the WAV header chunk parser: directed files, then random ones.
`timescale 1ns / 100ps

module wav_header_chunk_parser_test;
  import wavhdr_pkg::*;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] TAG_LIST = 32'h4c49_5354;
  localparam logic [15:0] FMT_PCM  = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam int SETTLE_CYCLES   = 6;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int ITEM_BUDGET     = 1950;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RLEN, PH_WAVE, PH_CTAG, PH_CLEN, PH_SKIP, PH_FTAG,
    PH_FCH, PH_FRATE, PH_FAVG, PH_FALIGN, PH_FBITS, PH_DATA, PH_IDLE
  } wav_phase_e;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic         cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // parser image
  wav_phase_e  wav_phase;
  logic [2:0]  field_count;
  logic [31:0] tag_window;
  logic [31:0] le_value;
  logic [32:0] skip_left;
  logic [31:0] byte_pos;
  logic [15:0] fmt_tag_held;
  logic [15:0] channels_held;
  logic [31:0] rate_held;
  logic [15:0] width_held;
  logic [31:0] audio_left;
  logic        pcm_only;

  result_t     results_due[$];
  result_t     oldest_due;
  logic [7:0]  file_bytes[$];
  logic [15:0] refused_tags [10] = '{16'h0000, 16'h0002, 16'h0006, 16'h0007, 16'h0010,
                                     16'h0015, 16'h0016, 16'h0101, 16'h0102, 16'h0103};

  int mismatches = 0;
  int results_seen = 0;
  int rejects_seen = 0;
  int bytes_parsed = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold = 0;

  wav_header_chunk_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    wav_phase     = PH_RIFF;
    field_count   = '0;
    tag_window    = '0;
    le_value      = '0;
    skip_left     = '0;
    byte_pos      = '0;
    fmt_tag_held  = '0;
    channels_held = '0;
    rate_held     = '0;
    width_held    = '0;
    audio_left    = '0;
  endfunction

  function automatic bit shift_tag(input logic [7:0] b);
    tag_window  = {tag_window[23:0], b};
    field_count = field_count + 3'd1;
    if (field_count >= 3'd4) begin
      field_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // little-endian field of n bytes
  function automatic bit gather_le(input logic [7:0] b, input logic [2:0] n,
                                   output logic [31:0] v);
    v           = '0;
    le_value    = le_value | (32'(b) << (8 * field_count[1:0]));
    field_count = field_count + 3'd1;
    if (field_count >= n) begin
      v           = le_value;
      le_value    = '0;
      field_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit format_refused(input logic [15:0] t);
    if (pcm_only) return t != FMT_PCM;
    return t == 16'h0000 || t == 16'h0002 || t == 16'h0006 || t == 16'h0007 ||
           t == 16'h0010 || t == 16'h0015 || t == 16'h0016 || t == 16'h0101 ||
           t == 16'h0102 || t == 16'h0103;
  endfunction

  // Advance the parser image by one accepted byte and queue the result it causes.
  task automatic parse_wav_byte(input logic [7:0] b, input logic start, input logic eof);
    logic [31:0] v;
    logic [31:0] pos;
    logic [32:0] padded;
    err_e        err;
    result_t     res;
    bit          has;
    err = ERR_NONE;
    has = 1'b0;
    res = '0;
    v   = '0;
    if (start) clear_parser();
    if (wav_phase >= PH_IDLE) begin
      wav_phase = PH_IDLE;
    end else begin
      bytes_parsed++;
      pos      = byte_pos;
      byte_pos = pos + 32'd1;
      case (wav_phase)
        PH_RIFF: begin
          if (shift_tag(b)) begin
            if (tag_window != TAG_RIFF) err = ERR_NOT_RIFF;
            else wav_phase = PH_RLEN;
          end
        end
        PH_RLEN: begin
          if (gather_le(b, 3'd4, v)) wav_phase = PH_WAVE;
        end
        PH_WAVE: begin
          if (shift_tag(b)) begin
            if (tag_window != TAG_WAVE) err = ERR_NOT_WAVE;
            else wav_phase = PH_CTAG;
          end
        end
        PH_CTAG: begin
          if (shift_tag(b)) wav_phase = PH_CLEN;
        end
        PH_CLEN: begin
          if (gather_le(b, 3'd4, v)) begin
            padded = {1'b0, v} + 33'(v[0]);
            if (width_held == 0 && tag_window == TAG_FMT) begin
              if (v < 32'd16) begin
                err = ERR_FMT_SHORT;
              end else begin
                skip_left = padded - 33'd16;
                wav_phase = PH_FTAG;
              end
            end else if (width_held != 0 && tag_window == TAG_DATA) begin
              audio_left        = v;
              res.kind          = KIND_HEADER;
              res.error_code    = ERR_NONE;
              res.wave_format   = fmt_tag_held;
              res.channel_count = channels_held;
              res.sample_rate   = rate_held;
              res.sample_width  = width_held[4:0];
              res.data_length   = v;
              res.audio_start   = pos + 32'd1;
              has               = 1'b1;
              wav_phase         = (v != 0) ? PH_DATA : PH_IDLE;
            end else begin
              skip_left = padded;
              wav_phase = (padded != 0) ? PH_SKIP : PH_CTAG;
            end
          end
        end
        PH_SKIP: begin
          skip_left = skip_left - 33'd1;
          if (skip_left == 0) wav_phase = PH_CTAG;
        end
        PH_FTAG: begin
          if (gather_le(b, 3'd2, v)) begin
            fmt_tag_held = v[15:0];
            if (format_refused(v[15:0])) err = ERR_FORMAT;
            else wav_phase = PH_FCH;
          end
        end
        PH_FCH: begin
          if (gather_le(b, 3'd2, v)) begin
            channels_held = v[15:0];
            wav_phase     = PH_FRATE;
          end
        end
        PH_FRATE: begin
          if (gather_le(b, 3'd4, v)) begin
            rate_held = v;
            wav_phase = PH_FAVG;
          end
        end
        PH_FAVG: begin
          if (gather_le(b, 3'd4, v)) wav_phase = PH_FALIGN;
        end
        PH_FALIGN: begin
          if (gather_le(b, 3'd2, v)) wav_phase = PH_FBITS;
        end
        PH_FBITS: begin
          if (gather_le(b, 3'd2, v)) begin
            if (v != 32'd8 && v != 32'd16) begin
              err = ERR_WIDTH;
            end else begin
              width_held = v[15:0];
              wav_phase  = (skip_left != 0) ? PH_SKIP : PH_CTAG;
            end
          end
        end
        PH_DATA: begin
          res.kind          = KIND_AUDIO;
          res.error_code    = ERR_NONE;
          res.wave_format   = fmt_tag_held;
          res.channel_count = channels_held;
          res.sample_rate   = rate_held;
          res.sample_width  = width_held[4:0];
          res.audio_byte    = b;
          res.last          = (audio_left == 32'd1);
          has               = 1'b1;
          audio_left        = audio_left - 32'd1;
          if (audio_left == 0) wav_phase = PH_IDLE;
        end
        default: wav_phase = PH_IDLE;
      endcase
      // an end of file before the parser finished overrides this byte's result
      if (err == ERR_NONE && eof && wav_phase != PH_IDLE) err = ERR_TRUNC;
      if (err != ERR_NONE) begin
        wav_phase      = PH_IDLE;
        res            = '0;
        res.kind       = KIND_REJECT;
        res.error_code = err;
        has            = 1'b1;
      end
      if (has) results_due.push_back(res);
    end
  endtask

  // ---------------- file builders ----------------

  function automatic void put_tag(input logic [31:0] t);
    file_bytes.push_back(t[31:24]);
    file_bytes.push_back(t[23:16]);
    file_bytes.push_back(t[15:8]);
    file_bytes.push_back(t[7:0]);
  endfunction

  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_noise(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_chunk(input logic [31:0] t, input logic [31:0] len);
    put_tag(t);
    put_le(len, 4);
    put_noise(int'(len) + int'(len[0]));
  endfunction

  function automatic void put_riff_head();
    file_bytes.delete();
    put_tag(TAG_RIFF);
    put_le($urandom, 4);
    put_tag(TAG_WAVE);
  endfunction

  function automatic void put_fmt(input logic [15:0] ftag, input logic [15:0] chans,
                                  input logic [31:0] rate, input logic [15:0] sbits,
                                  input logic [31:0] fmt_len);
    put_tag(TAG_FMT);
    put_le(fmt_len, 4);
    if (fmt_len < 32'd16) begin
      put_noise(int'(fmt_len) + int'(fmt_len[0]));
    end else begin
      put_le(32'(ftag), 2);
      put_le(32'(chans), 2);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(32'(sbits), 2);
      put_noise(int'(fmt_len) - 16 + int'(fmt_len[0]));
    end
  endfunction

  function automatic void put_data(input logic [31:0] len, input int count);
    put_tag(TAG_DATA);
    put_le(len, 4);
    put_noise(count);
  endfunction

  // ---------------- drivers ----------------

  task automatic send_byte(input logic [7:0] b, input logic start, input logic eof);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = start;
    s_axis_tlast  = eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    parse_wav_byte(b, start, eof);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Send file_bytes; eof_at < 0 sends all of it without an end-of-file mark.
  task automatic send_file(input bit with_start, input int eof_at);
    int stop_at;
    stop_at = (eof_at >= 0) ? eof_at : file_bytes.size() - 1;
    for (int i = 0; i <= stop_at; i++)
      send_byte(file_bytes[i], with_start && i == 0, i == eof_at);
    files_sent++;
  endtask

  task automatic send_wav(input logic [15:0] ftag, input logic [15:0] chans,
                          input logic [31:0] rate, input logic [15:0] sbits,
                          input logic [31:0] fmt_len, input int data_count);
    put_riff_head();
    put_fmt(ftag, chans, rate, sbits, fmt_len);
    put_data(data_count, data_count);
    send_file(1'b1, file_bytes.size() - 1);
  endtask

  task automatic wait_results_done();
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_pcm_only(input logic value);
    wait_results_done();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    pcm_only    = value;
  endtask

  // ---------------- result side ----------------

  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      m_axis_tready = 1'b0;
      recv_hold     = recv_hold - 1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string field_name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("result with nothing pending: kind %0d tdata 0x%0h", m_axis_tuser,
               m_axis_tdata);
        mismatches++;
      end else begin
        oldest_due = results_due.pop_front();
        results_seen++;
        if (oldest_due.kind == KIND_REJECT) rejects_seen++;
        check_field("kind", 32'(oldest_due.kind), 32'(m_axis_tuser));
        check_field("error_code", 32'(oldest_due.error_code), 32'(m_axis_tdata[2:0]));
        check_field("wave_format", 32'(oldest_due.wave_format), 32'(m_axis_tdata[18:3]));
        check_field("channel_count", 32'(oldest_due.channel_count),
                    32'(m_axis_tdata[34:19]));
        check_field("sample_rate", oldest_due.sample_rate, m_axis_tdata[66:35]);
        check_field("sample_width", 32'(oldest_due.sample_width),
                    32'(m_axis_tdata[71:67]));
        check_field("data_length", oldest_due.data_length, m_axis_tdata[103:72]);
        check_field("audio_start", oldest_due.audio_start, m_axis_tdata[135:104]);
        check_field("audio_byte", 32'(oldest_due.audio_byte), 32'(m_axis_tdata[143:136]));
        check_field("last", 32'(oldest_due.last), 32'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("wav_header_chunk_parser_test: done, errors");
      $finish;
    end
  end

  // ---------------- tests ----------------

  task automatic test_header_rejects();
    file_bytes.delete();
    put_tag(32'h5249_4658);
    put_noise(3);
    send_file(1'b1, -1);
    file_bytes.delete();
    put_tag(TAG_RIFF);
    put_le(32'hFFFF_FFFF, 4);
    put_tag(32'h5741_5644);
    send_file(1'b1, -1);
    // fmt one byte too short
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd15);
    send_file(1'b1, -1);
    foreach (refused_tags[i]) send_wav(refused_tags[i], 16'd2, 32'd44100, 16'd16, 32'd16, 2);
    send_wav(FMT_PCM, 16'd1, 32'd8000, 16'd0, 32'd16, 2);
    send_wav(FMT_PCM, 16'd1, 32'd8000, 16'd24, 32'd16, 2);
    send_wav(FMT_PCM, 16'd1, 32'd8000, 16'hFFFF, 32'd16, 2);
    // end of file inside the RIFF tag, inside fmt, on the data header, inside data
    put_riff_head();
    send_file(1'b1, 2);
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16);
    send_file(1'b1, 25);
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16);
    put_data(32'd6, 6);
    send_file(1'b1, file_bytes.size() - 7);
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16);
    put_data(32'd6, 6);
    send_file(1'b1, file_bytes.size() - 3);
  endtask

  task automatic test_good_files();
    send_wav(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16, 5);
    send_wav(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd16, 32'd16, 3);
    send_wav(FMT_FLOAT, 16'd0, 32'd0, 16'd8, 32'd17, 2);
    // data ahead of fmt, odd chunk, a second fmt and an empty chunk are all skipped
    put_riff_head();
    put_chunk(TAG_DATA, 32'd3);
    put_chunk(TAG_LIST, 32'd5);
    put_fmt(FMT_PCM, 16'd2, 32'd22050, 16'd16, 32'd18);
    put_chunk(TAG_FMT, 32'd16);
    put_chunk(TAG_LIST, 32'd0);
    put_data(32'd7, 7);
    send_file(1'b1, file_bytes.size() - 1);
    // empty data chunk, then bytes the idle parser ignores
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd11025, 16'd8, 32'd16);
    put_data(32'd0, 0);
    put_noise(4);
    send_file(1'b1, file_bytes.size() - 1);
    // a whole file without the start mark is ignored
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16);
    put_data(32'd2, 2);
    send_file(1'b0, file_bytes.size() - 1);
    // restart in the middle of fmt
    send_file(1'b1, -1);
    file_bytes = file_bytes[0:29];
    send_file(1'b1, -1);
    // huge data length, cut short by end of file
    put_riff_head();
    put_fmt(FMT_PCM, 16'd1, 32'd48000, 16'd16, 32'd16);
    put_data(32'hFFFF_FFFF, 6);
    send_file(1'b1, file_bytes.size() - 1);
    // huge skip count, abandoned by a restart
    put_riff_head();
    put_tag(TAG_LIST);
    put_le(32'hFFFF_FFFF, 4);
    put_noise(8);
    send_file(1'b1, -1);
    send_wav(FMT_PCM, 16'd2, 32'd96000, 16'd16, 32'd16, 4);
  endtask

  task automatic test_pcm_only();
    write_pcm_only(1'b1);
    send_wav(FMT_PCM, 16'd1, 32'd8000, 16'd8, 32'd16, 3);
    send_wav(FMT_FLOAT, 16'd1, 32'd8000, 16'd8, 32'd16, 3);
    send_wav(16'hFFFF, 16'd1, 32'd8000, 16'd8, 32'd16, 3);
    write_pcm_only(1'b0);
    send_wav(FMT_FLOAT, 16'd1, 32'd8000, 16'd8, 32'd16, 3);
  endtask

  // Hold the result side off while the sender keeps pushing audio bytes.
  task automatic test_full_stall();
    wait_results_done();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = HOLD_OFF_CYCLES;
    send_wav(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16, 60);
    wait_results_done();
  endtask

  task automatic send_random_file();
    logic [15:0] ftag;
    logic [15:0] sbits;
    logic [31:0] fmt_len;
    logic [31:0] data_len;
    int          data_count;
    int          eof_at;
    int          pick;
    int          flip_at;
    pick = $urandom_range(99);
    if (pick < 60) ftag = FMT_PCM;
    else if (pick < 75) ftag = FMT_FLOAT;
    else if (pick < 85) ftag = refused_tags[$urandom_range(9)];
    else ftag = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 85) sbits = $urandom_range(1) ? 16'd16 : 16'd8;
    else sbits = 16'($urandom_range(40));
    pick = $urandom_range(99);
    if (pick < 70) fmt_len = 32'd16;
    else if (pick < 95) fmt_len = 32'd16 + $urandom_range(7);
    else fmt_len = $urandom_range(15);
    pick = $urandom_range(99);
    if (pick < 80) data_len = $urandom_range(24);
    else if (pick < 95) data_len = $urandom_range(120, 25);
    else data_len = $urandom | 32'h8000_0000;
    data_count = (data_len > 32'd120) ? $urandom_range(40) : int'(data_len);
    put_riff_head();
    if ($urandom_range(9) == 0) put_chunk(TAG_DATA, $urandom_range(9));
    repeat ($urandom_range(2)) put_chunk($urandom, $urandom_range(9));
    put_fmt(ftag, 16'($urandom), $urandom, sbits, fmt_len);
    if ($urandom_range(9) == 0) put_chunk(TAG_FMT, 32'd16);
    repeat ($urandom_range(1)) put_chunk(TAG_LIST, $urandom_range(5));
    put_data(data_len, data_count);
    if ($urandom_range(99) < 8) begin
      flip_at = $urandom_range(file_bytes.size() - 1);
      file_bytes[flip_at] = file_bytes[flip_at] ^ (8'd1 << $urandom_range(7));
    end
    pick = $urandom_range(99);
    if (pick < 80) eof_at = file_bytes.size() - 1;
    else if (pick < 90) eof_at = $urandom_range(file_bytes.size() - 1);
    else eof_at = -1;
    send_file($urandom_range(19) != 0, eof_at);
    if ($urandom_range(9) == 0) begin
      file_bytes.delete();
      put_noise($urandom_range(5, 1));
      send_file(1'b0, -1);
    end
  endtask

  // Spread what is left of the item budget over the four idle mixes.
  task automatic test_random_files();
    int idle_send [4] = '{0, 66, 0, 34};
    int idle_recv [4] = '{0, 0, 66, 34};
    int goal;
    int share;
    for (int p = 0; p < 4; p++) begin
      if (p == 1) write_pcm_only(1'b1);
      else if (p == 2) write_pcm_only(1'($urandom_range(1)));
      else write_pcm_only(1'b0);
      send_idle_pct  = idle_send[p];
      recv_stall_pct = idle_recv[p];
      share = (ITEM_BUDGET - bytes_sent) / (4 - p);
      goal  = bytes_sent + share;
      while (bytes_sent < goal) send_random_file();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    clear_parser();
    pcm_only = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_header_rejects();
    test_good_files();
    test_pcm_only();
    test_full_stall();
    test_random_files();
    wait_results_done();
    $display("run summary: %0d files, %0d bytes sent, %0d parsed, %0d results, %0d rejections",
             files_sent, bytes_sent, bytes_parsed, results_seen, rejects_seen);
    $display("run summary: every error code, both PCM-only settings, four idle mixes, one long output stall");
    if (mismatches == 0) begin
      $display("wav_header_chunk_parser_test: done, clean");
    end else begin
      $display("wav_header_chunk_parser_test: done, errors");
    end
    $finish;
  end

endmodule
